/* sv/radar_uart_frame_deframer_defines.svh */
// assertion macros for the radar uart frame deframer
`ifndef RADAR_UART_FRAME_DEFRAMER_DEFINES_SVH
`define RADAR_UART_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle implication, checked on clk_i, off while in reset
`define RUFD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk_i, off while in reset
`define RUFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/rufd_pkg.sv */
// package: phase, kind and register codes plus frame type classifier
package rufd_pkg;

  localparam logic [7:0]  START_BYTE_RST    = 8'h01;
  localparam logic [15:0] MAX_LENGTH_RST    = 16'd1024;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [9:0] {
    PH_HUNT    = 10'b00_0000_0001,
    PH_ID_H    = 10'b00_0000_0010,
    PH_ID_L    = 10'b00_0000_0100,
    PH_LEN_H   = 10'b00_0000_1000,
    PH_LEN_L   = 10'b00_0001_0000,
    PH_TYPE_H  = 10'b00_0010_0000,
    PH_TYPE_L  = 10'b00_0100_0000,
    PH_HEAD_CK = 10'b00_1000_0000,
    PH_DATA    = 10'b01_0000_0000,
    PH_DATA_CK = 10'b10_0000_0000
  } phase_e;

  typedef enum logic [2:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_GOOD     = 3'd1,
    KIND_HDR_ERR  = 3'd2,
    KIND_DATA_ERR = 3'd3,
    KIND_LEN_ERR  = 3'd4
  } kind_e;

  localparam logic [2:0] CLASS_OTHER = 3'd7;

  function automatic logic [2:0] class_of(input logic [15:0] t);
    logic [2:0] c;
    case (t)
      16'h0F09: c = 3'd0;
      16'h0A04: c = 3'd1;
      16'h0A13: c = 3'd2;
      16'h0A14: c = 3'd3;
      16'h0A15: c = 3'd4;
      16'h0A16: c = 3'd5;
      16'h0A17: c = 3'd6;
      default:  c = CLASS_OTHER;
    endcase
    return c;
  endfunction

endpackage

/* sv/radar_uart_frame_deframer.sv */
// radar uart frame deframer: byte/tick parser with one result register
// a result is registered and shows on the outputs in the cycle after its request is taken
// throughput: one request per cycle; the result register sits between the sides
// so a new request is taken whenever the result register is empty or being drained
// reset (async, active low): parser hunting, all held fields and counters zero,
// registers back to start 0x01, max length 1024, timeout 1000 ticks
module radar_uart_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [7:0]  rx_byte_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] byte_index_o,
  output logic [15:0] frame_ident_o,
  output logic [15:0] frame_length_o,
  output logic [15:0] frame_kind_code_o,
  output logic [2:0]  type_class_o
);

`include "radar_uart_frame_deframer_defines.svh"

  // configuration registers
  logic [7:0]  start_byte_q;
  logic [15:0] max_length_q;
  logic [15:0] timeout_ticks_q;

  // parser state
  rufd_pkg::phase_e phase_q, phase_d;
  logic [15:0] ident_q, ident_d;
  logic [15:0] length_q, length_d;
  logic [15:0] type_q, type_d;
  logic [7:0]  pxor_q, pxor_d;
  logic [15:0] count_q, count_d;
  logic [15:0] idle_q, idle_d;

  // result of the current request
  logic              res_valid;
  rufd_pkg::kind_e   res_kind;
  logic [7:0]        res_byte;
  logic [15:0]       res_index;
  logic [15:0]       res_type;
  logic [2:0]        res_class;

  // output register
  logic              out_valid_q;
  rufd_pkg::kind_e   kind_q;
  logic [7:0]        payload_byte_q;
  logic [15:0]       byte_index_q;
  logic [15:0]       ident_out_q;
  logic [15:0]       length_out_q;
  logic [15:0]       type_out_q;
  logic [2:0]        class_q;

  logic in_acc;
  logic [7:0] head_ck;
  logic [15:0] count_inc;

  // shorthands for the checks at the end
  logic tick_acc;
  logic in_data;
  logic data_acc;
  logic payload_out;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q    <= rufd_pkg::START_BYTE_RST;
      max_length_q    <= rufd_pkg::MAX_LENGTH_RST;
      timeout_ticks_q <= rufd_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        rufd_pkg::REG_START_BYTE:    start_byte_q    <= cfg_data_i[7:0];
        rufd_pkg::REG_MAX_LENGTH:    max_length_q    <= cfg_data_i;
        rufd_pkg::REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // take a request whenever the result register is free or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  // header checksum uses the start byte register as it stands at the check
  assign head_ck = ~(start_byte_q ^ ident_q[15:8] ^ ident_q[7:0] ^
                     length_q[15:8] ^ length_q[7:0] ^ type_q[15:8] ^ type_q[7:0]);
  assign count_inc = count_q + 16'd1;

  // one pass of the parser per request
  always_comb begin
    phase_d   = phase_q;
    ident_d   = ident_q;
    length_d  = length_q;
    type_d    = type_q;
    pxor_d    = pxor_q;
    count_d   = count_q;
    idle_d    = idle_q;
    res_valid = 1'b0;
    res_kind  = rufd_pkg::KIND_GOOD;
    res_byte  = 8'd0;
    res_index = 16'd0;
    res_type  = type_q;
    res_class = rufd_pkg::class_of(type_q);

    if (opcode_i == rufd_pkg::OP_TICK) begin
      // saturating idle counter; timeout drops a partial frame silently
      if (idle_q != 16'hFFFF) idle_d = idle_q + 16'd1;
      if (idle_d > timeout_ticks_q && phase_q != rufd_pkg::PH_HUNT) begin
        phase_d = rufd_pkg::PH_HUNT;
      end
    end else begin
      idle_d = 16'd0;
      case (phase_q)
        rufd_pkg::PH_HUNT: begin
          if (rx_byte_i == start_byte_q) phase_d = rufd_pkg::PH_ID_H;
        end
        rufd_pkg::PH_ID_H: begin
          ident_d = {rx_byte_i, 8'd0};
          phase_d = rufd_pkg::PH_ID_L;
        end
        rufd_pkg::PH_ID_L: begin
          ident_d = {ident_q[15:8], rx_byte_i};
          phase_d = rufd_pkg::PH_LEN_H;
        end
        rufd_pkg::PH_LEN_H: begin
          length_d = {rx_byte_i, 8'd0};
          phase_d  = rufd_pkg::PH_LEN_L;
        end
        rufd_pkg::PH_LEN_L: begin
          length_d = {length_q[15:8], rx_byte_i};
          if (length_d > max_length_q) begin
            // type not yet seen: report zero type, other class
            phase_d   = rufd_pkg::PH_HUNT;
            res_valid = 1'b1;
            res_kind  = rufd_pkg::KIND_LEN_ERR;
            res_type  = 16'd0;
            res_class = rufd_pkg::CLASS_OTHER;
          end else begin
            phase_d = rufd_pkg::PH_TYPE_H;
          end
        end
        rufd_pkg::PH_TYPE_H: begin
          type_d  = {rx_byte_i, 8'd0};
          phase_d = rufd_pkg::PH_TYPE_L;
        end
        rufd_pkg::PH_TYPE_L: begin
          type_d  = {type_q[15:8], rx_byte_i};
          phase_d = rufd_pkg::PH_HEAD_CK;
        end
        rufd_pkg::PH_HEAD_CK: begin
          if (rx_byte_i != head_ck) begin
            phase_d   = rufd_pkg::PH_HUNT;
            res_valid = 1'b1;
            res_kind  = rufd_pkg::KIND_HDR_ERR;
          end else if (length_q == 16'd0) begin
            // empty frame completes at the header
            phase_d   = rufd_pkg::PH_HUNT;
            res_valid = 1'b1;
            res_kind  = rufd_pkg::KIND_GOOD;
          end else begin
            pxor_d  = 8'd0;
            count_d = 16'd0;
            phase_d = rufd_pkg::PH_DATA;
          end
        end
        rufd_pkg::PH_DATA: begin
          res_valid = 1'b1;
          res_kind  = rufd_pkg::KIND_PAYLOAD;
          res_byte  = rx_byte_i;
          res_index = count_q;
          pxor_d    = pxor_q ^ rx_byte_i;
          count_d   = count_inc;
          if (count_inc >= length_q) phase_d = rufd_pkg::PH_DATA_CK;
        end
        rufd_pkg::PH_DATA_CK: begin
          phase_d   = rufd_pkg::PH_HUNT;
          res_valid = 1'b1;
          res_kind  = (rx_byte_i == ~pxor_q) ? rufd_pkg::KIND_GOOD
                                             : rufd_pkg::KIND_DATA_ERR;
        end
        default: phase_d = rufd_pkg::PH_HUNT;
      endcase
    end
  end

  // parser state advances only on a taken request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= rufd_pkg::PH_HUNT;
      ident_q  <= 16'd0;
      length_q <= 16'd0;
      type_q   <= 16'd0;
      pxor_q   <= 8'd0;
      count_q  <= 16'd0;
      idle_q   <= 16'd0;
    end else if (in_acc) begin
      phase_q  <= phase_d;
      ident_q  <= ident_d;
      length_q <= length_d;
      type_q   <= type_d;
      pxor_q   <= pxor_d;
      count_q  <= count_d;
      idle_q   <= idle_d;
    end
  end

  // result register: valid under reset, payload loads with each result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && res_valid) begin
      kind_q         <= res_kind;
      payload_byte_q <= res_byte;
      byte_index_q   <= res_index;
      ident_out_q    <= ident_d;
      length_out_q   <= length_d;
      type_out_q     <= res_type;
      class_q        <= res_class;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = kind_q;
  assign payload_byte_o    = payload_byte_q;
  assign byte_index_o      = byte_index_q;
  assign frame_ident_o     = ident_out_q;
  assign frame_length_o    = length_out_q;
  assign frame_kind_code_o = type_out_q;
  assign type_class_o      = class_q;

  assign tick_acc    = in_acc && (opcode_i == rufd_pkg::OP_TICK);
  assign in_data     = (phase_q == rufd_pkg::PH_DATA);
  assign data_acc    = in_acc && (opcode_i == rufd_pkg::OP_BYTE) && in_data;
  assign payload_out = out_valid_q && (kind_q == rufd_pkg::KIND_PAYLOAD);

  // a result only appears after a taken request
  `RUFD_ASSERT_SAME(a_result_from_request, $rose(out_valid_q), $past(in_acc), "stray result")
  // ticks never produce a result
  `RUFD_ASSERT_NEXT(a_tick_silent, tick_acc, !out_valid_q, "tick made a result")
  // a byte inside the payload is always forwarded
  `RUFD_ASSERT_NEXT(a_payload_fwd, data_acc, payload_out, "payload byte not forwarded")
  // payload count stays below the header length while gathering payload
  `RUFD_ASSERT_SAME(a_count_in_range, in_data, count_q < length_q, "count past length")

endmodule
